@@ rtl/rmst_pkg.sv @@
// ----------------------------------------------------------------------------
// rmst_pkg
// Shared types, constants and helpers for the range-maximum sparse table.
// ----------------------------------------------------------------------------
package rmst_pkg;

  localparam int DEPTH_DEF  = 1024;
  localparam int LEVELS_DEF = 11;

  localparam int VALUE_W = 32;
  localparam int CNT_W   = 11;
  localparam int LOG_W   = $clog2(CNT_W);
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [CNT_W-1:0] ELEMENT_COUNT_RESET = CNT_W'(1024);

  // register index, taken from paddr above the byte offset
  localparam logic [PADDR_W-3:0] REG_ELEMENT_COUNT = '0;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef struct packed {
    logic             kind;
    logic [CNT_W-1:0] position;
    value_t           element_value;
    logic [CNT_W-1:0] left_index;
    logic [CNT_W-1:0] right_index;
  } req_t;

  typedef struct packed {
    value_t range_max;
    logic   query_valid;
  } rsp_t;

  // position of the highest set bit, 0 for a zero word
  function automatic logic [LOG_W-1:0] floor_log2(input logic [CNT_W-1:0] v);
    logic [LOG_W-1:0] res;
    res = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (v[i]) begin
        res = LOG_W'(i);
      end
    end
    return res;
  endfunction

endpackage

@@ rtl/range_max_sparse_table.sv @@
// ----------------------------------------------------------------------------
// range_max_sparse_table
// Range-maximum query engine over a sparse table held in one memory.
//
//   channel   dir  handshake                    word
//   req       in   req_valid / req_ready        rmst_pkg::req_t
//   rsp       out  rsp_valid / rsp_ready        rmst_pkg::rsp_t
//   cfg       in   psel/penable/pwrite/pready   element_count at byte 0
//
// A query while the table is current: table read, then compare in the shared
// max unit into the result register. The first query after a load or count
// write rebuilds the table first: per level k (2^k <= n) it writes one entry
// per cycle through the single write port, and the query then does its table
// read.
// Reset marks the table stale and sets element_count to 1024; no memory sweep.
// A full result register stalls the query in its result stage (ST_QDONE) only.
// ----------------------------------------------------------------------------
module range_max_sparse_table #(
  parameter int DEPTH  = rmst_pkg::DEPTH_DEF,
  parameter int LEVELS = rmst_pkg::LEVELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rmst_pkg::PADDR_W-1:0]  paddr,
  input  logic [rmst_pkg::PDATA_W-1:0]  pwdata,
  output logic [rmst_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  rmst_pkg::req_t                req,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output rmst_pkg::rsp_t                rsp
);
  import rmst_pkg::*;

  localparam int IW    = $clog2(DEPTH);
  localparam int KW    = $clog2(LEVELS);
  localparam int AW    = KW + IW;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int WORDS = LEVELS << IW;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_BUILD = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_QRD   = 5'b01000,
    ST_QDONE = 5'b10000
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] element_count;
  logic             table_current;
  logic [CNT_W-1:0] q_left;
  logic [CNT_W-1:0] q_right;
  logic             q_bad;
  logic [KW-1:0]    b_level;
  logic [IW-1:0]    b_idx;
  logic [IW-1:0]    wr_idx;
  logic             wr_pend;

  logic             idle;
  logic             req_fire;
  logic             cfg_write;
  logic             reg_hit;
  logic [CW-1:0]    n_cover;
  logic             pos_ok;
  logic             bad_now;
  logic [CNT_W-1:0] src_left;
  logic [CNT_W-1:0] src_right;
  logic [CNT_W-1:0] span;
  logic [LOG_W-1:0] log_raw;
  logic [KW-1:0]    q_level;
  logic [IW-1:0]    win_start;
  logic [IW-1:0]    win_end;
  logic [KW-1:0]    b_prev;
  logic [IW-1:0]    b_half_idx;
  logic             build_last;
  logic             level_more;
  logic             out_free;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  value_t           mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr_a;
  logic [AW-1:0]    mem_raddr_b;
  value_t           rd_a;
  value_t           rd_b;
  value_t           max_out;

  assign idle      = (state == ST_IDLE);
  assign req_ready = idle;
  assign req_fire  = req_valid && req_ready;
  assign out_free  = !rsp_valid || rsp_ready;

  // configuration port
  assign pready    = 1'b1;
  assign reg_hit   = (paddr[PADDR_W-1:2] == REG_ELEMENT_COUNT);
  assign cfg_write = psel && penable && pwrite && pready && reg_hit;
  assign prdata    = reg_hit ? PDATA_W'(element_count) : '0;

  assign n_cover = (int'(element_count) > DEPTH) ? CW'(DEPTH) : CW'(element_count);

  assign pos_ok  = (req.position != '0) && (int'(req.position) <= DEPTH);
  assign bad_now = (req.left_index == '0) || (req.left_index > req.right_index) ||
                   (int'(req.right_index) > int'(n_cover));

  // window addresses, straight from the request word while idle
  assign src_left  = idle ? req.left_index  : q_left;
  assign src_right = idle ? req.right_index : q_right;
  assign span      = src_right - src_left + CNT_W'(1);
  assign log_raw   = floor_log2(span);
  assign q_level   = (int'(log_raw) > LEVELS - 1) ? KW'(LEVELS - 1) : KW'(log_raw);
  assign win_start = IW'(src_left - CNT_W'(1));
  assign win_end   = IW'(src_right - (CNT_W'(1) << q_level));

  // build walk
  assign b_prev     = b_level - KW'(1);
  assign b_half_idx = IW'(int'(b_idx) + (1 << int'(b_prev)));
  assign build_last = (int'(b_idx) + (1 << int'(b_level))) == int'(n_cover);
  assign level_more = (int'(b_level) + 1 < LEVELS) &&
                      ((1 << (int'(b_level) + 1)) <= int'(n_cover));

  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = {b_level, wr_idx};
    mem_wdata   = max_out;
    mem_re      = 1'b0;
    mem_raddr_a = {q_level, win_start};
    mem_raddr_b = {q_level, win_end};
    unique case (state)
      ST_IDLE: begin
        mem_we    = req_fire && (req.kind == KIND_LOAD) && pos_ok;
        mem_waddr = {KW'(0), IW'(req.position - CNT_W'(1))};
        mem_wdata = req.element_value;
        mem_re    = req_fire && (req.kind == KIND_QUERY);
      end
      ST_BUILD: begin
        mem_we      = wr_pend;
        mem_re      = 1'b1;
        mem_raddr_a = {b_prev, b_idx};
        mem_raddr_b = {b_prev, b_half_idx};
      end
      ST_DRAIN: begin
        mem_we = 1'b1;
      end
      ST_QRD: begin
        mem_re = 1'b1;
      end
      ST_QDONE: begin
      end
      default: begin
      end
    endcase
  end

  rmst_table_mem #(
    .AW    (AW),
    .WORDS (WORDS)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  rmst_max_unit u_max (
    .a       (rd_a),
    .b       (rd_b),
    .max_out (max_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      element_count <= ELEMENT_COUNT_RESET;
      table_current <= 1'b0;
      wr_pend       <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      // the result stage sets valid itself when it hands over a new word
      if (rsp_valid && rsp_ready && (state != ST_QDONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cfg_write) begin
            element_count <= pwdata[CNT_W-1:0];
            table_current <= 1'b0;
          end
          if (req_fire) begin
            if (req.kind == KIND_LOAD) begin
              if (pos_ok) begin
                table_current <= 1'b0;
              end
            end else begin
              q_left  <= req.left_index;
              q_right <= req.right_index;
              q_bad   <= bad_now;
              if (bad_now || table_current) begin
                state <= ST_QDONE;
              end else if (n_cover >= CW'(2)) begin
                b_level <= KW'(1);
                b_idx   <= '0;
                wr_pend <= 1'b0;
                state   <= ST_BUILD;
              end else begin
                table_current <= 1'b1;
                state         <= ST_QRD;
              end
            end
          end
        end
        ST_BUILD: begin
          wr_pend <= 1'b1;
          wr_idx  <= b_idx;
          if (build_last) begin
            state <= ST_DRAIN;
          end else begin
            b_idx <= b_idx + IW'(1);
          end
        end
        ST_DRAIN: begin
          wr_pend <= 1'b0;
          if (level_more) begin
            b_level <= b_level + KW'(1);
            b_idx   <= '0;
            state   <= ST_BUILD;
          end else begin
            table_current <= 1'b1;
            state         <= ST_QRD;
          end
        end
        ST_QRD: begin
          state <= ST_QDONE;
        end
        ST_QDONE: begin
          // hold until the result register is free
          if (out_free) begin
            rsp.range_max   <= q_bad ? value_t'(0) : max_out;
            rsp.query_valid <= !q_bad;
            rsp_valid       <= 1'b1;
            state           <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_no_write_in_query: assert property (@(posedge clk) disable iff (rst)
    (state == ST_QRD || state == ST_QDONE) |-> !mem_we)
    else $error("table written during query");

  a_table_ready: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_QRD) || (state == ST_QDONE && !q_bad)) |-> table_current)
    else $error("query reads a stale table");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == ST_QDONE)
    else $error("result word from outside the result stage");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.query_valid) |-> (rsp.range_max == 0))
    else $error("invalid query carries a non-zero maximum");

endmodule

@@ rtl/rmst_table_mem.sv @@
// ----------------------------------------------------------------------------
// rmst_table_mem
// Table storage: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module rmst_table_mem #(
  parameter int AW    = 14,
  parameter int WORDS = 11264
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  rmst_pkg::value_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr_a,
  input  logic [AW-1:0]   raddr_b,
  output rmst_pkg::value_t rdata_a,
  output rmst_pkg::value_t rdata_b
);
  import rmst_pkg::*;

  value_t mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold read data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ rtl/rmst_max_unit.sv @@
// ----------------------------------------------------------------------------
// rmst_max_unit
// Shared signed compare and select, used by table build and by queries.
// ----------------------------------------------------------------------------
module rmst_max_unit (
  input  rmst_pkg::value_t a,
  input  rmst_pkg::value_t b,
  output rmst_pkg::value_t max_out
);
  import rmst_pkg::*;

  logic a_wins;

  assign a_wins  = (a > b);
  assign max_out = a_wins ? a : b;

endmodule

@@ tb/sv/range_max_sparse_table_checker.sv @@
// ----------------------------------------------------------------------------
// range_max_sparse_table_checker
// Watches the register port and both word channels of the range-maximum
// engine, keeps an image of the loaded array and the element count, works out
// the result of every accepted query by a plain scan of the range and compares
// it field by field with the words that leave the block, in order.
// ----------------------------------------------------------------------------
module range_max_sparse_table_checker
  import rmst_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               pready,
  input  logic               req_valid,
  input  logic               req_ready,
  input  req_t               req,
  input  logic               rsp_valid,
  input  logic               rsp_ready,
  input  rsp_t               rsp,
  output int unsigned        mismatches,
  output int unsigned        queries_in_flight
);

  timeunit 1ns;
  timeprecision 1ps;

  value_t           array_image [DEPTH];
  logic [CNT_W-1:0] covered_count;
  rsp_t             awaited_maxima [$];
  rsp_t             oldest;
  int unsigned      fault_tally;

  // maximum over the closed range, or an invalid word for a bad range
  function automatic rsp_t range_max_of(input logic [CNT_W-1:0] lo,
                                        input logic [CNT_W-1:0] hi);
    int unsigned n;
    int unsigned i;
    rsp_t        res;
    value_t      best;
    n = (covered_count > DEPTH) ? DEPTH : covered_count;
    res.range_max   = '0;
    res.query_valid = 1'b0;
    if (lo < 1 || lo > hi || hi > n) begin
      return res;
    end
    best = array_image[lo - 1];
    for (i = lo; i < hi; i++) begin
      if (array_image[i] > best) begin
        best = array_image[i];
      end
    end
    res.range_max   = best;
    res.query_valid = 1'b1;
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      covered_count = ELEMENT_COUNT_RESET;
      awaited_maxima.delete();
      fault_tally = 0;
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr[PADDR_W-1:2] == REG_ELEMENT_COUNT) begin
        covered_count = pwdata[CNT_W-1:0];
      end
      if (req_valid && req_ready) begin
        if (req.kind == KIND_LOAD) begin
          // drop loads outside the array
          if (req.position >= 1 && req.position <= DEPTH) begin
            array_image[req.position - 1] = req.element_value;
          end
        end else begin
          awaited_maxima.push_back(range_max_of(req.left_index, req.right_index));
        end
      end
      if (rsp_valid && rsp_ready) begin
        if (awaited_maxima.size() == 0) begin
          $error("result word with no query waiting: range_max %0d query_valid %0b",
                 rsp.range_max, rsp.query_valid);
          fault_tally++;
        end else begin
          oldest = awaited_maxima.pop_front();
          if (rsp.range_max !== oldest.range_max) begin
            $error("range_max mismatch: expected %0d, actual %0d",
                   oldest.range_max, rsp.range_max);
            fault_tally++;
          end
          if (rsp.query_valid !== oldest.query_valid) begin
            $error("query_valid mismatch: expected %0b, actual %0b",
                   oldest.query_valid, rsp.query_valid);
            fault_tally++;
          end
        end
      end
    end
    mismatches        <= fault_tally;
    queries_in_flight <= awaited_maxima.size();
  end

endmodule

@@ tb/sv/range_max_sparse_table_tb.sv @@
// ----------------------------------------------------------------------------
// range_max_sparse_table_tb
// Drives loads and range queries into the range-maximum engine under several
// element counts, from empty and oversized counts down to a single element,
// with random gaps on the request side and random stalls on the result side.
// A checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module range_max_sparse_table_tb;

  import rmst_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          N_MAX  = DEPTH_DEF;
  localparam int          FILL   = 256;
  localparam int          SETTLE = 8;
  localparam int unsigned LIMIT  = 1_000_000;
  localparam int          PHASES = 12;
  localparam int          PHASE_WORDS = 30;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [PDATA_W-1:0] pwdata    = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               req_valid = 1'b0;
  logic               req_ready;
  req_t               req       = '0;
  logic               rsp_valid;
  logic               rsp_ready = 1'b0;
  rsp_t               rsp;

  int unsigned        mismatches;
  int unsigned        queries_in_flight;
  int unsigned        cycle_count = 0;
  int unsigned        sink_hold   = 0;
  logic               sink_stalls = 1'b0;
  bit                 src_calm    = 1'b0;
  logic [CNT_W-1:0]   count_setting = ELEMENT_COUNT_RESET;

  always #10 clk = ~clk;

  range_max_sparse_table u_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  range_max_sparse_table_checker u_chk (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .pready            (pready),
    .req_valid         (req_valid),
    .req_ready         (req_ready),
    .req               (req),
    .rsp_valid         (rsp_valid),
    .rsp_ready         (rsp_ready),
    .rsp               (rsp),
    .mismatches        (mismatches),
    .queries_in_flight (queries_in_flight)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end
    if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // result side: alternate ready and stalled stretches while stalls are on
  always @(posedge clk) begin
    if (!sink_stalls) begin
      rsp_ready <= 1'b1;
      sink_hold <= 0;
    end else if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
    end else if (rsp_ready) begin
      rsp_ready <= 1'b0;
      sink_hold <= pick_gap();
    end else begin
      rsp_ready <= 1'b1;
      sink_hold <= $urandom_range(0, 12);
    end
  end

  function automatic req_t make_load(input int unsigned pos, input logic [31:0] val);
    req_t w;
    w.kind          = KIND_LOAD;
    w.position      = CNT_W'(pos);
    w.element_value = value_t'(val);
    w.left_index    = CNT_W'($urandom);
    w.right_index   = CNT_W'($urandom);
    return w;
  endfunction

  function automatic req_t make_query(input int unsigned lo, input int unsigned hi);
    req_t w;
    w.kind          = KIND_QUERY;
    w.position      = CNT_W'($urandom);
    w.element_value = value_t'($urandom);
    w.left_index    = CNT_W'(lo);
    w.right_index   = CNT_W'(hi);
    return w;
  endfunction

  function automatic int unsigned covered();
    return (count_setting > N_MAX) ? N_MAX : count_setting;
  endfunction

  // legal ranges stay inside the filled prefix of the array
  function automatic int unsigned queryable();
    return (covered() > FILL) ? FILL : covered();
  endfunction

  function automatic logic [31:0] random_value();
    if ($urandom_range(0, 99) < 15) begin
      case ($urandom_range(0, 4))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return 32'h0000_0000;
        3:       return 32'hFFFF_FFFF;
        default: return 32'h0000_0001;
      endcase
    end
    return $urandom;
  endfunction

  function automatic req_t random_load();
    int unsigned roll;
    int unsigned n;
    int unsigned pos;
    n    = (covered() == 0) ? 1 : covered();
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      pos = $urandom_range(0, 1) ? 0 : $urandom_range(N_MAX + 1, 2047);
    end else if (roll < 12) begin
      pos = $urandom_range(1, N_MAX);
    end else begin
      pos = $urandom_range(1, n);
    end
    return make_load(pos, random_value());
  endfunction

  function automatic req_t random_query();
    int unsigned n;
    int unsigned m;
    int unsigned roll;
    int unsigned lo;
    int unsigned hi;
    int unsigned k;
    int unsigned len;
    n    = covered();
    m    = queryable();
    roll = $urandom_range(0, 99);
    if (n == 0 || roll < 20) begin
      case ($urandom_range(0, 2))
        0: begin
          lo = 0;
          hi = $urandom_range(0, 2047);
        end
        1: begin
          lo = $urandom_range(2, 2047);
          hi = $urandom_range(0, lo - 1);
        end
        default: begin
          hi = $urandom_range(n + 1, 2047);
          lo = $urandom_range(0, hi);
        end
      endcase
    end else if (roll < 35) begin
      // window of exactly a power of two
      k = 0;
      while ((2 << k) <= m) begin
        k++;
      end
      len = 1 << $urandom_range(0, k);
      lo  = $urandom_range(1, m - len + 1);
      hi  = lo + len - 1;
    end else if (roll < 45) begin
      lo = $urandom_range(1, m);
      hi = lo;
    end else if (roll < 52) begin
      lo = 1;
      hi = m;
    end else begin
      lo = $urandom_range(1, m);
      hi = $urandom_range(lo, m);
    end
    return make_query(lo, hi);
  endfunction

  // hold the word until accepted, then maybe drop valid for a while
  task automatic send_word(input req_t word);
    int unsigned gap;
    req       <= word;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) begin
      @(posedge clk);
    end
    gap = src_calm ? 0 : pick_gap();
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait for every outstanding result, then let the block go quiet
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (queries_in_flight != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_count(input logic [CNT_W-1:0] value);
    drain();
    paddr   <= {REG_ELEMENT_COUNT, 2'b00};
    pwdata  <= PDATA_W'(value);
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    count_setting  = value;
  endtask

  initial begin
    logic [CNT_W-1:0] plan [PHASES];
    int unsigned      p;
    int unsigned      i;
    bit               heavy;
    bit               calm;
    bit               is_load;

    plan = '{11'd1024, 11'd1, 11'd2, 11'd3, 11'd17, 11'd64, 11'd2047, 11'd0,
             11'd127, 11'd300, 11'd5, 11'd1024};

    repeat (12) @(posedge clk);
    rst         <= 1'b0;
    sink_stalls <= 1'b1;

    // extremes at the reset count, ignored loads, bad ranges
    send_word(make_load(1, 32'h7FFF_FFFF));
    send_word(make_load(2, 32'h8000_0000));
    send_word(make_load(3, 32'hFFFF_FFFF));
    send_word(make_load(4, 32'h0000_0000));
    send_word(make_load(5, 32'h0000_0001));
    send_word(make_load(N_MAX, 32'hFFFF_FFFB));
    send_word(make_load(0, 32'd123));
    send_word(make_load(N_MAX + 1, 32'd99));
    send_word(make_load(2047, 32'd7));
    send_word(make_query(1, 5));
    send_word(make_query(2, 2));
    send_word(make_query(2, 3));
    send_word(make_query(N_MAX, N_MAX));
    send_word(make_query(0, 3));
    send_word(make_query(4, 3));
    send_word(make_query(1, N_MAX + 1));
    send_word(make_query(2047, 2047));
    send_word(make_load(3, 32'h7FFF_FFFF));
    send_word(make_query(2, 4));
    send_word(make_query(3, 5));

    // empty count: every query is out of range
    set_count(11'd0);
    send_word(make_query(1, 1));
    send_word(make_query(0, 0));

    // a load past the count is stored and shows up once the count grows
    set_count(11'd3);
    send_word(make_load(6, 32'd1000));
    send_word(make_query(1, 3));
    send_word(make_query(1, 6));
    set_count(11'd6);
    send_word(make_query(4, 6));

    // oversized count acts as the full array
    set_count(11'd2047);
    send_word(make_query(N_MAX, N_MAX));
    send_word(make_query(N_MAX + 1, N_MAX + 1));

    // fill the low part of the array so every later legal range is defined
    set_count(11'd1024);
    for (i = 1; i <= FILL; i++) begin
      send_word(make_load(i, random_value()));
    end
    send_word(make_query(1, FILL));
    send_word(make_query(1, FILL / 2));
    send_word(make_query(FILL / 2 + 1, FILL));
    send_word(make_query(2, FILL));
    send_word(make_query(1, FILL - 1));
    send_word(make_query(200, 201));

    for (p = 0; p < PHASES; p++) begin
      set_count(plan[p]);
      calm        = ($urandom_range(0, 3) == 0);
      src_calm    = calm;
      sink_stalls <= !calm;
      // large counts rebuild slowly: batch the loads at the start
      heavy = (covered() >= 256);
      for (i = 0; i < PHASE_WORDS; i++) begin
        if (heavy) begin
          is_load = (i < 6);
        end else begin
          is_load = ($urandom_range(0, 99) < 30);
        end
        if (p == 4 && i == PHASE_WORDS / 2) begin
          drain();
        end
        send_word(is_load ? random_load() : random_query());
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/rmst_pkg.sv
rtl/rmst_table_mem.sv
rtl/rmst_max_unit.sv
rtl/range_max_sparse_table.sv
tb/sv/range_max_sparse_table_checker.sv
tb/sv/range_max_sparse_table_tb.sv
